// ===== src/ctp_pkg.sv =====
// Shared types and constants for the countdown timer pool.
// Used by ctp_tick_mem, ctp_ctrl, countdown_timer_pool and the testbench; depends on nothing.
package ctp_pkg;

  localparam int TICKS_W     = 32;
  localparam int HANDLE_W    = 4;
  localparam int CMD_W       = 2;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int MAX_SLOTS   = 16;
  localparam int SLOTS_DEF   = 16;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 8;

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } result_t;

endpackage

// ===== src/ctp_tick_mem.sv =====
// Remaining-tick store: one write port, one read port, registered read data.
// Depends on ctp_pkg for the tick count width and the default depth.
module ctp_tick_mem #(
  parameter int DEPTH  = ctp_pkg::SLOTS_DEF,
  parameter int ADDR_W = 4
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [ctp_pkg::TICKS_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [ctp_pkg::TICKS_W-1:0] rdata_o
);

  logic [ctp_pkg::TICKS_W-1:0] mem [DEPTH];
  logic [ctp_pkg::TICKS_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued, so the walker can stall.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ctp_ctrl.sv =====
// Command sequencer: slot valid bits, create/cancel handling, the tick walk
// over the tick store, and the result register. Depends on ctp_pkg.
module ctp_ctrl #(
  parameter int USED_SLOTS = ctp_pkg::SLOTS_DEF,
  parameter int IDX_W      = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ctp_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic [ctp_pkg::TICKS_W-1:0]   in_ticks_i,
  input  logic [ctp_pkg::HANDLE_W-1:0]  in_target_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ctp_pkg::result_t              out_res_o,
  output logic                          mem_we_o,
  output logic [IDX_W-1:0]              mem_waddr_o,
  output logic [ctp_pkg::TICKS_W-1:0]   mem_wdata_o,
  output logic                          mem_re_o,
  output logic [IDX_W-1:0]              mem_raddr_o,
  input  logic [ctp_pkg::TICKS_W-1:0]   mem_rdata_i
);

  localparam int CNT_W = $clog2(USED_SLOTS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(USED_SLOTS);
  localparam logic [ctp_pkg::HANDLE_W:0] USED_LIM = (ctp_pkg::HANDLE_W + 1)'(USED_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_e;

  state_e                  state_q, state_d;
  logic [USED_SLOTS-1:0]   active_q, active_d;
  logic [CNT_W-1:0]        rd_cnt_q, rd_cnt_d;
  logic                    ev_v_q, ev_v_d;
  logic [IDX_W-1:0]        ev_idx_q, ev_idx_d;
  logic                    pend_v_q, pend_v_d;
  logic [IDX_W-1:0]        pend_idx_q, pend_idx_d;
  logic                    out_v_q, out_v_d;
  ctp_pkg::result_t        out_q, out_d;

  logic                    out_free;
  logic                    accept;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;
  logic                    tgt_ok;
  logic                    ev_act;
  logic                    ev_expire;
  logic                    block;
  logic                    advance;

  assign out_free   = !out_v_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Lowest-numbered free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = USED_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign tgt_ok = ({1'b0, in_target_i} < USED_LIM) && active_q[in_target_i[IDX_W-1:0]];

  assign ev_act    = active_q[ev_idx_q];
  assign ev_expire = ev_act && (mem_rdata_i[ctp_pkg::TICKS_W-1:1] == '0);
  // An expiry can only be taken when the held one can move to the result register.
  assign block     = ev_v_q && ev_expire && pend_v_q && !out_free;
  assign advance   = !block;

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    rd_cnt_d    = rd_cnt_q;
    ev_v_d      = ev_v_q;
    ev_idx_d    = ev_idx_q;
    pend_v_d    = pend_v_q;
    pend_idx_d  = pend_idx_q;
    out_v_d     = out_v_q && !out_ready_i;
    out_d       = out_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = free_idx;
    mem_wdata_o = in_ticks_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_cnt_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            ctp_pkg::CMD_CREATE: begin
              out_v_d     = 1'b1;
              out_d.kind  = ctp_pkg::KIND_CREATE;
              out_d.last  = 1'b1;
              if (free_found) begin
                active_d[free_idx] = 1'b1;
                mem_we_o           = 1'b1;
                out_d.status       = ctp_pkg::ST_OK;
                out_d.handle       = ctp_pkg::HANDLE_W'(free_idx);
              end else begin
                out_d.status = ctp_pkg::ST_FULL;
                out_d.handle = '0;
              end
            end
            ctp_pkg::CMD_CANCEL: begin
              out_v_d      = 1'b1;
              out_d.kind   = ctp_pkg::KIND_CANCEL;
              out_d.last   = 1'b1;
              out_d.handle = in_target_i;
              if (tgt_ok) begin
                active_d[in_target_i[IDX_W-1:0]] = 1'b0;
                out_d.status = ctp_pkg::ST_OK;
              end else begin
                out_d.status = ctp_pkg::ST_INACTIVE;
              end
            end
            ctp_pkg::CMD_TICK: begin
              state_d  = S_WALK;
              rd_cnt_d = '0;
              ev_v_d   = 1'b0;
              pend_v_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        // Evaluate the slot whose count the last issued read returned.
        if (ev_v_q && advance) begin
          mem_waddr_o = ev_idx_q;
          if (ev_expire) begin
            active_d[ev_idx_q] = 1'b0;
            if (pend_v_q) begin
              out_v_d      = 1'b1;
              out_d.kind   = ctp_pkg::KIND_EXPIRE;
              out_d.status = ctp_pkg::ST_OK;
              out_d.handle = ctp_pkg::HANDLE_W'(pend_idx_q);
              out_d.last   = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_idx_d = ev_idx_q;
          end else if (ev_act) begin
            mem_we_o    = 1'b1;
            mem_wdata_o = mem_rdata_i - ctp_pkg::TICKS_W'(1);
          end
        end
        // Issue the next read.
        if (advance) begin
          if (rd_cnt_q != LAST_CNT) begin
            mem_re_o = 1'b1;
            ev_v_d   = 1'b1;
            ev_idx_d = rd_cnt_q[IDX_W-1:0];
            rd_cnt_d = rd_cnt_q + CNT_W'(1);
          end else begin
            ev_v_d  = 1'b0;
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_v_d      = 1'b1;
          out_d.status = ctp_pkg::ST_OK;
          out_d.last   = 1'b1;
          if (pend_v_q) begin
            out_d.kind   = ctp_pkg::KIND_EXPIRE;
            out_d.handle = ctp_pkg::HANDLE_W'(pend_idx_q);
          end else begin
            out_d.kind   = ctp_pkg::KIND_IDLE;
            out_d.handle = '0;
          end
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= '0;
      rd_cnt_q <= '0;
      ev_v_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      rd_cnt_q <= rd_cnt_d;
      ev_v_q   <= ev_v_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q   <= ev_idx_d;
    pend_idx_q <= pend_idx_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

endmodule

// ===== src/countdown_timer_pool.sv =====
// Countdown timer pool: top level, stream ports around ctp_ctrl and ctp_tick_mem.
// Create and cancel give their reply in the cycle after the request is taken.
// Tick: walks the tick store one slot per cycle through its single read port, unless an
// expiry waits for the result side; the next request is taken after the last result.
// One create or cancel is taken per cycle while the result side does not stall. Reset clears every slot to free;
// the tick store needs no clearing since a free slot's count is never used.
module countdown_timer_pool #(
  parameter int TIMER_SLOTS = ctp_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: start_ticks [31:0], target_handle [35:32], zero fill [39:36]
  input  logic [ctp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: command
  input  logic [ctp_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: status [1:0], slot_handle [5:2], zero fill [7:6]
  output logic [ctp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // tuser: result_kind
  output logic [ctp_pkg::KIND_W-1:0]      m_axis_tuser,
  output logic                            m_axis_tlast
);

  localparam int USED_SLOTS = (TIMER_SLOTS < ctp_pkg::MAX_SLOTS) ? TIMER_SLOTS
                                                                  : ctp_pkg::MAX_SLOTS;
  localparam int IDX_W = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;

  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [ctp_pkg::TICKS_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [IDX_W-1:0]            mem_raddr;
  logic [ctp_pkg::TICKS_W-1:0] mem_rdata;
  ctp_pkg::result_t            res;

  ctp_ctrl #(
    .USED_SLOTS (USED_SLOTS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_ticks_i  (s_axis_tdata[ctp_pkg::TICKS_W-1:0]),
    .in_target_i (s_axis_tdata[ctp_pkg::TICKS_W +: ctp_pkg::HANDLE_W]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ctp_tick_mem #(
    .DEPTH  (USED_SLOTS),
    .ADDR_W (IDX_W)
  ) u_tick_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata = {2'b00, res.handle, res.status};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// ===== tb/countdown_timer_pool_test.sv =====
// Self-checking testbench for countdown_timer_pool: directed and random create, cancel and
// tick requests under random stalls on both stream sides, checked against a local predictor.
// Depends on ctp_pkg and countdown_timer_pool.
module countdown_timer_pool_test;

  localparam int POOL_SLOTS = 16;
  localparam int RANDOM_REQS = 240;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [ctp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [ctp_pkg::CMD_W-1:0]    cmd;
    logic [ctp_pkg::TICKS_W-1:0]  ticks;
    logic [ctp_pkg::HANDLE_W-1:0] target;
  } timer_req_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [ctp_pkg::IN_DATA_W-1:0] s_axis_tdata;
  logic [ctp_pkg::CMD_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [ctp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [ctp_pkg::KIND_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  timer_req_t req_backlog[$];
  ctp_pkg::result_t expected_results[$];
  logic slot_busy[POOL_SLOTS];
  logic [ctp_pkg::TICKS_W-1:0] slot_count[POOL_SLOTS];

  int mismatches = 0;
  int reqs_queued = 0;
  int reqs_accepted = 0;
  int req_gap = 0;
  int ready_stall = 0;
  bit gaps_off = 0;
  logic req_fire = 1'b0;

  countdown_timer_pool #(
    .TIMER_SLOTS(POOL_SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Mostly short gaps, a few long ones, and now and then a stretch with none at all.
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 49) == 0) gaps_off = !gaps_off;
    if (gaps_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic queue_req(logic [ctp_pkg::CMD_W-1:0] cmd, logic [ctp_pkg::TICKS_W-1:0] ticks,
                           logic [ctp_pkg::HANDLE_W-1:0] target);
    timer_req_t req;
    req.cmd = cmd;
    req.ticks = ticks;
    req.target = target;
    req_backlog.push_back(req);
    reqs_queued++;
  endtask

  task automatic report_mismatch(string what, int got_v, int want_v);
    $display("%0t: mismatch in %s: got %0d, want %0d", $realtime, what, got_v, want_v);
    mismatches++;
  endtask

  // Works out the results one accepted request causes and updates the pool state.
  function automatic void predict_timer_results(timer_req_t req);
    ctp_pkg::result_t res;
    bit found;
    int fired;
    res = '0;
    found = 0;
    fired = 0;
    case (req.cmd)
      ctp_pkg::CMD_CREATE: begin
        res.kind = ctp_pkg::KIND_CREATE;
        res.status = ctp_pkg::ST_FULL;
        res.last = 1'b1;
        for (int i = 0; i < POOL_SLOTS; i++) begin
          if (!found && !slot_busy[i]) begin
            found = 1;
            slot_busy[i] = 1'b1;
            slot_count[i] = req.ticks;
            res.status = ctp_pkg::ST_OK;
            res.handle = ctp_pkg::HANDLE_W'(i);
          end
        end
        expected_results.push_back(res);
      end
      ctp_pkg::CMD_CANCEL: begin
        res.kind = ctp_pkg::KIND_CANCEL;
        res.handle = req.target;
        res.last = 1'b1;
        if (int'(req.target) < POOL_SLOTS && slot_busy[req.target]) begin
          slot_busy[req.target] = 1'b0;
          slot_count[req.target] = '0;
          res.status = ctp_pkg::ST_OK;
        end else begin
          res.status = ctp_pkg::ST_INACTIVE;
        end
        expected_results.push_back(res);
      end
      ctp_pkg::CMD_TICK: begin
        for (int i = 0; i < POOL_SLOTS; i++) begin
          if (slot_busy[i]) begin
            // A count of zero expires like a count of one instead of wrapping.
            if (slot_count[i] <= 1) begin
              slot_busy[i] = 1'b0;
              slot_count[i] = '0;
              res.kind = ctp_pkg::KIND_EXPIRE;
              res.status = ctp_pkg::ST_OK;
              res.handle = ctp_pkg::HANDLE_W'(i);
              res.last = 1'b0;
              expected_results.push_back(res);
              fired++;
            end else begin
              slot_count[i] = slot_count[i] - 1;
            end
          end
        end
        if (fired == 0) begin
          res.kind = ctp_pkg::KIND_IDLE;
          res.status = ctp_pkg::ST_OK;
          res.handle = '0;
          res.last = 1'b1;
          expected_results.push_back(res);
        end else begin
          res = expected_results.pop_back();
          res.last = 1'b1;
          expected_results.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  // Driver: holds each request until it is taken, then waits out a random gap, and stalls m_axis_tready at random.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || req_fire) begin
        if (req_gap > 0) begin
          req_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          timer_req_t req;
          req = req_backlog.pop_front();
          s_axis_tuser <= req.cmd;
          s_axis_tdata <= {4'b0, req.target, req.ticks};
          s_axis_tvalid <= 1'b1;
          req_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (ready_stall > 0) begin
        ready_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) ready_stall = pick_gap();
      end
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        timer_req_t req;
        req.cmd = s_axis_tuser;
        req.ticks = s_axis_tdata[31:0];
        req.target = s_axis_tdata[35:32];
        predict_timer_results(req);
        reqs_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result kind", m_axis_tuser, 0);
        end else begin
          ctp_pkg::result_t want;
          want = expected_results.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch("result_kind", m_axis_tuser, want.kind);
          if (m_axis_tdata[1:0] !== want.status)
            report_mismatch("status", m_axis_tdata[1:0], want.status);
          if (m_axis_tdata[5:2] !== want.handle)
            report_mismatch("slot_handle", m_axis_tdata[5:2], want.handle);
          if (m_axis_tlast !== want.last)
            report_mismatch("last", m_axis_tlast, want.last);
        end
      end
    end
  end

  initial begin
    int create_w;
    int r;
    logic [ctp_pkg::TICKS_W-1:0] ticks;
    logic [ctp_pkg::HANDLE_W-1:0] target;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_count[i] = '0;
    end
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ctp_pkg::CMD_CREATE;
    m_axis_tready = 1'b0;

    // Directed part: empty tick, zero start count, extremes, cancels, unused code, full pool.
    queue_req(ctp_pkg::CMD_TICK, 32'hFFFF_FFFF, 4'hF);
    queue_req(ctp_pkg::CMD_CREATE, 32'd0, 4'h0);
    queue_req(ctp_pkg::CMD_TICK, 32'd0, 4'h0);
    queue_req(ctp_pkg::CMD_CREATE, 32'd1, 4'hF);
    queue_req(ctp_pkg::CMD_CREATE, 32'hFFFF_FFFF, 4'h0);
    queue_req(ctp_pkg::CMD_CREATE, 32'd2, 4'h0);
    queue_req(ctp_pkg::CMD_CANCEL, 32'hFFFF_FFFF, 4'd1);
    queue_req(ctp_pkg::CMD_CANCEL, 32'd0, 4'd1);
    queue_req(ctp_pkg::CMD_CANCEL, 32'd0, 4'hF);
    queue_req(CMD_UNUSED, 32'hFFFF_FFFF, 4'hF);
    queue_req(ctp_pkg::CMD_TICK, 32'd0, 4'h0);
    queue_req(ctp_pkg::CMD_TICK, 32'd0, 4'h0);
    for (int i = 0; i < POOL_SLOTS + 1; i++) queue_req(ctp_pkg::CMD_CREATE, 32'd1, 4'h0);
    queue_req(ctp_pkg::CMD_TICK, 32'd0, 4'h0);

    // Random part in segments, each leaning toward filling or draining the pool.
    for (int seg = 0; seg < RANDOM_REQS / 40; seg++) begin
      create_w = ($urandom_range(0, 2) == 0) ? 65 : $urandom_range(20, 45);
      for (int n = 0; n < 40; n++) begin
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: ticks = $urandom_range(0, 4);
          10, 11, 12, 13, 14, 15: ticks = $urandom_range(5, 40);
          16, 17, 18: ticks = $urandom;
          default: ticks = 32'hFFFF_FFFF;
        endcase
        if ($urandom_range(0, 9) < 7) target = ctp_pkg::HANDLE_W'($urandom_range(0, 7));
        else target = ctp_pkg::HANDLE_W'($urandom);
        if (r < create_w) queue_req(ctp_pkg::CMD_CREATE, ticks, target);
        else if (r < create_w + (100 - create_w) / 3) queue_req(ctp_pkg::CMD_CANCEL, ticks, target);
        else if (r < 96) queue_req(ctp_pkg::CMD_TICK, ticks, target);
        else queue_req(CMD_UNUSED, ticks, target);
      end
    end
    // Drain whatever is still counting so the long timers get cancelled.
    for (int i = 0; i < POOL_SLOTS; i++) begin
      queue_req(ctp_pkg::CMD_CANCEL, $urandom, ctp_pkg::HANDLE_W'(i));
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (reqs_accepted == reqs_queued);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
